[src/rpvt_pkg.sv]
// ----------------------------------------------------------------------------
// rpvt_pkg
// Shared widths, codes, reset values and handshake structs of the reflector
// position and velocity tracker.
// ----------------------------------------------------------------------------
package rpvt_pkg;

	localparam int unsigned POS_W      = 20;
	localparam int unsigned SPD_W      = 20;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned SPACE_W    = 16;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned STRIP_W    = 8;
	localparam int unsigned DEB_W      = 8;
	localparam int unsigned ZONE_W     = 2;
	localparam int unsigned STAT_W     = 2;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 20;
	localparam int unsigned TDATA_W    = 64;
	localparam int unsigned PROD_W     = 2 * SPACE_W;
	// Spacing times 1000 stays below 2^26.
	localparam int unsigned DIVD_W     = 26;
	localparam int unsigned DIV_CNT_W  = 5;
	localparam int unsigned SUM_W      = PROD_W + 1;

	localparam logic [POS_W-1:0]   POS_MAX     = '1;
	localparam logic [SPD_W-1:0]   SPD_MAX     = '1;
	localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
	localparam logic [POS_W:0]     ZONE_LEN_MM = 21'd4000;
	localparam logic [TIME_W-1:0]  CALC_MIN_MS = 32'd2;
	localparam logic [SPACE_W-1:0] SPEED_SCALE = 16'd1000;

	// Register reset values.
	localparam logic [SPACE_W-1:0] RST_REFL_SPACING = 16'd4000;
	localparam logic [SPACE_W-1:0] RST_STRIP_SPACING = 16'd50;
	localparam logic [POS_W-1:0]   RST_FIRST_REFL   = 20'd5000;
	localparam logic [POS_W-1:0]   RST_ZONE_ONE     = 20'd86000;
	localparam logic [POS_W-1:0]   RST_ZONE_TWO     = 20'd138000;
	localparam logic [POS_W-1:0]   RST_TUNNEL       = 20'd5000;
	localparam logic [POS_W-1:0]   RST_BRAKE        = 20'd176000;
	localparam logic [DEB_W-1:0]   RST_DEBOUNCE     = 8'd20;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_REFL_SPACING  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP_SPACING = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_REFL    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_ONE      = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_TWO      = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TUNNEL        = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BRAKE         = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 8'd7;

	localparam logic [ZONE_W-1:0] ZONE_NORMAL = 2'd0;
	localparam logic [ZONE_W-1:0] ZONE_ONE    = 2'd1;
	localparam logic [ZONE_W-1:0] ZONE_TWO    = 2'd2;
	localparam logic [ZONE_W-1:0] ZONE_RSVD   = 2'd3;

	localparam logic [STAT_W-1:0] STAT_READY   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RUNNING = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BRAKING = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SPD_MUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_SPD_WR,
		ST_POS_MUL,
		ST_POS_ADD,
		ST_ZONE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_item;
		logic reject;
		logic touch_pulse;
		logic cnt_strip;
		logic cnt_refl;
		logic mul_spd;
		logic div_init;
		logic div_step;
		logic spd_load;
		logic mul_pos;
		logic pos_load;
		logic zone_load;
		logic status_load;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic func;
		logic bounce;
		logic in_zone;
		logic spd_go;
		logic div_last;
		logic out_full;
	} sts_t;

endpackage

[src/reflector_position_velocity_tracker_unit.sv]
// ----------------------------------------------------------------------------
// reflector_position_velocity_tracker_unit
// Tracks vehicle position and speed from timestamped reflector pulses.
// ----------------------------------------------------------------------------
// Input words arrive on s_*: tdata is the millisecond timestamp, tuser is 1
// for a recompute request and 0 for a sensor pulse. One result word per input
// leaves on m_*: tuser is the accepted flag, tdata carries position, speed,
// zone, run status and the reflector count.
// The configuration channel (cfg_*) writes one register per word; it is
// always ready and must only be used while no word is in flight.
// Words are taken one at a time. A rejected pulse or a pulse inside a marker
// zone goes from the check step straight to the output step. A recompute or
// a normal pulse also passes the speed multiply, position multiply, position
// add and zone steps, and the division steps when a new speed is computed:
// the speed divider retires one quotient bit per cycle.
// The result register frees the sequencer, so a new word is accepted while
// the previous result still waits. A stalled receiver holds the sequencer in
// its last step until the result register can be reloaded.
// Reset restores the register defaults, sets the position to the default
// tunnel start and clears all counts, speed, status and timestamps.
// ----------------------------------------------------------------------------
module reflector_position_velocity_tracker_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rpvt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rpvt_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rpvt_pkg::TIME_W-1:0]        s_tdata,   // time_ms
	input  logic                               s_tuser,   // func
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// position_mm[19:0], speed_mm_s[39:20], zone[41:40], run_status[43:42],
	// reflectors_seen[59:44], zero fill above
	output logic [rpvt_pkg::TDATA_W-1:0]       m_tdata,
	output logic                               m_tuser    // accepted
);

	rpvt_pkg::cmd_t cmd;
	rpvt_pkg::sts_t sts;

	rpvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	rpvt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

[src/rpvt_ctrl.sv]
// ----------------------------------------------------------------------------
// rpvt_ctrl
// Sequencer of the tracker: takes one word at a time and steps the datapath
// through debounce, speed division, position and zone update.
// ----------------------------------------------------------------------------
module rpvt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output rpvt_pkg::cmd_t  cmd,
	input  rpvt_pkg::sts_t  sts
);

	rpvt_pkg::state_t state_q;
	rpvt_pkg::state_t state_nxt;
	logic             pulse_q;
	logic             pulse_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpvt_pkg::ST_IDLE;
			pulse_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			pulse_q <= pulse_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		pulse_nxt = pulse_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			rpvt_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_nxt     = rpvt_pkg::ST_CHECK;
				end
			end
			rpvt_pkg::ST_CHECK: begin
				pulse_nxt = 1'b0;
				if (sts.func) begin
					state_nxt = rpvt_pkg::ST_SPD_MUL;
				end else if (sts.bounce) begin
					cmd.reject = 1'b1;
					state_nxt  = rpvt_pkg::ST_OUT;
				end else if (sts.in_zone) begin
					// Inside a marker zone a pulse only counts a strip and records its time.
					cmd.touch_pulse = 1'b1;
					cmd.cnt_strip   = 1'b1;
					state_nxt       = rpvt_pkg::ST_OUT;
				end else begin
					cmd.touch_pulse = 1'b1;
					cmd.cnt_refl    = 1'b1;
					pulse_nxt       = 1'b1;
					state_nxt       = rpvt_pkg::ST_SPD_MUL;
				end
			end
			rpvt_pkg::ST_SPD_MUL: begin
				cmd.mul_spd = 1'b1;
				state_nxt   = sts.spd_go ? rpvt_pkg::ST_DIV_INIT : rpvt_pkg::ST_POS_MUL;
			end
			rpvt_pkg::ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_nxt    = rpvt_pkg::ST_DIV;
			end
			rpvt_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = rpvt_pkg::ST_SPD_WR;
				end
			end
			rpvt_pkg::ST_SPD_WR: begin
				cmd.spd_load = 1'b1;
				state_nxt    = rpvt_pkg::ST_POS_MUL;
			end
			rpvt_pkg::ST_POS_MUL: begin
				cmd.mul_pos = 1'b1;
				state_nxt   = rpvt_pkg::ST_POS_ADD;
			end
			rpvt_pkg::ST_POS_ADD: begin
				cmd.pos_load = 1'b1;
				state_nxt    = rpvt_pkg::ST_ZONE;
			end
			rpvt_pkg::ST_ZONE: begin
				cmd.zone_load   = 1'b1;
				cmd.status_load = pulse_q;
				state_nxt       = rpvt_pkg::ST_OUT;
			end
			rpvt_pkg::ST_OUT: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_nxt    = rpvt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = rpvt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[src/rpvt_dp.sv]
// ----------------------------------------------------------------------------
// rpvt_dp
// Datapath of the tracker: configuration registers, tracking state, one
// shared 16x16 multiplier, a radix-2 divider and the output word register.
// ----------------------------------------------------------------------------
module rpvt_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rpvt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rpvt_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [rpvt_pkg::TIME_W-1:0]          s_tdata,
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [rpvt_pkg::TDATA_W-1:0]         m_tdata,
	output logic                                 m_tuser,
	input  rpvt_pkg::cmd_t                       cmd,
	output rpvt_pkg::sts_t                       sts
);

	// Configuration registers.
	logic [rpvt_pkg::SPACE_W-1:0] refl_spacing_q;
	logic [rpvt_pkg::SPACE_W-1:0] strip_spacing_q;
	logic [rpvt_pkg::POS_W-1:0]   first_refl_q;
	logic [rpvt_pkg::POS_W-1:0]   zone_one_q;
	logic [rpvt_pkg::POS_W-1:0]   zone_two_q;
	logic [rpvt_pkg::POS_W-1:0]   tunnel_q;
	logic [rpvt_pkg::POS_W-1:0]   brake_q;
	logic [rpvt_pkg::DEB_W-1:0]   debounce_q;

	// Tracking state.
	logic [rpvt_pkg::CNT_W-1:0]   refl_total_q;
	logic [rpvt_pkg::POS_W-1:0]   pos_q;
	logic [rpvt_pkg::SPD_W-1:0]   speed_q;
	logic [rpvt_pkg::STAT_W-1:0]  status_q;
	logic [rpvt_pkg::TIME_W-1:0]  last_pulse_q;
	logic [rpvt_pkg::TIME_W-1:0]  last_calc_q;
	logic [rpvt_pkg::ZONE_W-1:0]  zone_q;
	logic [rpvt_pkg::STRIP_W-1:0] strip_total_q;
	logic                         calc_valid_q;

	// Current item and working registers.
	logic                         func_q;
	logic [rpvt_pkg::TIME_W-1:0]  time_q;
	logic                         accept_q;
	logic [rpvt_pkg::PROD_W-1:0]  prod_q;
	logic [rpvt_pkg::TIME_W-1:0]  rem_q;
	logic [rpvt_pkg::DIVD_W-1:0]  quo_q;
	logic [rpvt_pkg::DIV_CNT_W-1:0] div_cnt_q;

	logic                         out_valid_q;
	logic [rpvt_pkg::TDATA_W-1:0] out_data_q;
	logic                         out_user_q;

	logic [rpvt_pkg::TIME_W-1:0]  pulse_dt;
	logic [rpvt_pkg::TIME_W-1:0]  calc_dt;
	logic [rpvt_pkg::SPACE_W-1:0] mul_a;
	logic [rpvt_pkg::SPACE_W-1:0] mul_b;
	logic [rpvt_pkg::TIME_W:0]    trial;
	logic [rpvt_pkg::TIME_W:0]    trial_diff;
	logic                         trial_ge;
	logic [rpvt_pkg::SPD_W-1:0]   speed_sat;
	logic [rpvt_pkg::POS_W-1:0]   pos_base;
	logic [rpvt_pkg::SUM_W-1:0]   pos_sum;
	logic [rpvt_pkg::POS_W-1:0]   pos_next;
	logic [rpvt_pkg::POS_W:0]     zone_one_end;
	logic [rpvt_pkg::POS_W:0]     zone_two_end;
	logic                         in_zone_one;
	logic                         in_zone_two;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refl_spacing_q  <= rpvt_pkg::RST_REFL_SPACING;
			strip_spacing_q <= rpvt_pkg::RST_STRIP_SPACING;
			first_refl_q    <= rpvt_pkg::RST_FIRST_REFL;
			zone_one_q      <= rpvt_pkg::RST_ZONE_ONE;
			zone_two_q      <= rpvt_pkg::RST_ZONE_TWO;
			tunnel_q        <= rpvt_pkg::RST_TUNNEL;
			brake_q         <= rpvt_pkg::RST_BRAKE;
			debounce_q      <= rpvt_pkg::RST_DEBOUNCE;
		end else if (cfg_valid) begin
			case (cfg_index)
				rpvt_pkg::REG_REFL_SPACING:  refl_spacing_q  <= cfg_data[rpvt_pkg::SPACE_W-1:0];
				rpvt_pkg::REG_STRIP_SPACING: strip_spacing_q <= cfg_data[rpvt_pkg::SPACE_W-1:0];
				rpvt_pkg::REG_FIRST_REFL:    first_refl_q    <= cfg_data[rpvt_pkg::POS_W-1:0];
				rpvt_pkg::REG_ZONE_ONE:      zone_one_q      <= cfg_data[rpvt_pkg::POS_W-1:0];
				rpvt_pkg::REG_ZONE_TWO:      zone_two_q      <= cfg_data[rpvt_pkg::POS_W-1:0];
				rpvt_pkg::REG_TUNNEL:        tunnel_q        <= cfg_data[rpvt_pkg::POS_W-1:0];
				rpvt_pkg::REG_BRAKE:         brake_q         <= cfg_data[rpvt_pkg::POS_W-1:0];
				rpvt_pkg::REG_DEBOUNCE:      debounce_q      <= cfg_data[rpvt_pkg::DEB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign pulse_dt = time_q - last_pulse_q;
	assign calc_dt  = time_q - last_calc_q;

	// Shared multiplier: spacing times 1000 for speed, count times spacing for position.
	always_comb begin
		if (cmd.mul_spd) begin
			mul_a = (zone_q == rpvt_pkg::ZONE_NORMAL) ? refl_spacing_q : strip_spacing_q;
			mul_b = rpvt_pkg::SPEED_SCALE;
		end else if (zone_q == rpvt_pkg::ZONE_NORMAL) begin
			mul_a = refl_total_q;
			mul_b = refl_spacing_q;
		end else begin
			mul_a = rpvt_pkg::SPACE_W'(strip_total_q);
			mul_b = strip_spacing_q;
		end
	end

	// One quotient bit per cycle; the remainder always stays below the divisor.
	assign trial      = {rem_q, quo_q[rpvt_pkg::DIVD_W-1]};
	assign trial_ge   = trial >= {1'b0, calc_dt};
	assign trial_diff = trial - {1'b0, calc_dt};
	assign speed_sat  = (|quo_q[rpvt_pkg::DIVD_W-1:rpvt_pkg::SPD_W]) ? rpvt_pkg::SPD_MAX
	                    : quo_q[rpvt_pkg::SPD_W-1:0];

	always_comb begin
		case (zone_q)
			rpvt_pkg::ZONE_NORMAL: pos_base = first_refl_q;
			rpvt_pkg::ZONE_ONE:    pos_base = zone_one_q;
			default:               pos_base = zone_two_q;
		endcase
	end

	assign pos_sum  = rpvt_pkg::SUM_W'(pos_base) + rpvt_pkg::SUM_W'(prod_q);
	assign pos_next = (refl_total_q == '0) ? first_refl_q
	                : (|pos_sum[rpvt_pkg::SUM_W-1:rpvt_pkg::POS_W]) ? rpvt_pkg::POS_MAX
	                : pos_sum[rpvt_pkg::POS_W-1:0];

	assign zone_one_end = {1'b0, zone_one_q} + rpvt_pkg::ZONE_LEN_MM;
	assign zone_two_end = {1'b0, zone_two_q} + rpvt_pkg::ZONE_LEN_MM;
	assign in_zone_one  = (pos_q >= zone_one_q) && ({1'b0, pos_q} < zone_one_end);
	assign in_zone_two  = (pos_q >= zone_two_q) && ({1'b0, pos_q} < zone_two_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refl_total_q  <= '0;
			pos_q         <= rpvt_pkg::RST_TUNNEL;
			speed_q       <= '0;
			status_q      <= rpvt_pkg::STAT_READY;
			last_pulse_q  <= '0;
			last_calc_q   <= '0;
			zone_q        <= rpvt_pkg::ZONE_NORMAL;
			strip_total_q <= '0;
			calc_valid_q  <= 1'b0;
		end else begin
			if (cmd.touch_pulse) begin
				last_pulse_q <= time_q;
			end
			if (cmd.cnt_refl && (refl_total_q != rpvt_pkg::CNT_MAX)) begin
				refl_total_q <= refl_total_q + 1'b1;
			end
			if (cmd.spd_load) begin
				speed_q <= speed_sat;
			end
			if (cmd.pos_load) begin
				pos_q <= pos_next;
			end
			if (cmd.cnt_strip) begin
				strip_total_q <= strip_total_q + 1'b1;
			end else if (cmd.zone_load && !in_zone_one && !in_zone_two) begin
				strip_total_q <= '0;
			end
			if (cmd.zone_load) begin
				if (in_zone_one) begin
					zone_q <= rpvt_pkg::ZONE_ONE;
				end else if (in_zone_two) begin
					zone_q <= rpvt_pkg::ZONE_TWO;
				end else begin
					zone_q <= rpvt_pkg::ZONE_NORMAL;
				end
				last_calc_q  <= time_q;
				calc_valid_q <= 1'b1;
			end
			if (cmd.status_load) begin
				if (pos_q >= brake_q) begin
					status_q <= rpvt_pkg::STAT_BRAKING;
				end else if (pos_q > tunnel_q) begin
					status_q <= rpvt_pkg::STAT_RUNNING;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q   <= s_tuser;
			time_q   <= s_tdata;
			accept_q <= 1'b1;
		end else if (cmd.reject) begin
			accept_q <= 1'b0;
		end
		if (cmd.mul_spd || cmd.mul_pos) begin
			prod_q <= rpvt_pkg::PROD_W'(mul_a) * rpvt_pkg::PROD_W'(mul_b);
		end
		if (cmd.div_init) begin
			rem_q     <= '0;
			quo_q     <= prod_q[rpvt_pkg::DIVD_W-1:0];
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= trial_ge ? trial_diff[rpvt_pkg::TIME_W-1:0] : trial[rpvt_pkg::TIME_W-1:0];
			quo_q     <= {quo_q[rpvt_pkg::DIVD_W-2:0], trial_ge};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_user_q <= accept_q;
			out_data_q <= {4'b0, refl_total_q, status_q, zone_q, speed_q, pos_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	assign sts.func     = func_q;
	assign sts.bounce   = pulse_dt < rpvt_pkg::TIME_W'(debounce_q);
	assign sts.in_zone  = zone_q != rpvt_pkg::ZONE_NORMAL;
	assign sts.spd_go   = calc_valid_q && (calc_dt >= rpvt_pkg::CALC_MIN_MS);
	assign sts.div_last = div_cnt_q == rpvt_pkg::DIV_CNT_W'(rpvt_pkg::DIVD_W - 1);
	assign sts.out_full = out_valid_q && !m_tready;

`ifndef SYNTHESIS
	a_zone_code: assert property (@(posedge clk) disable iff (!arst_n)
		zone_q != rpvt_pkg::ZONE_RSVD)
		else $error("zone register holds an unused code");

	a_strip_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(zone_q == rpvt_pkg::ZONE_NORMAL) |-> (strip_total_q == '0))
		else $error("strip count nonzero outside a marker zone");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < calc_dt))
		else $error("divider remainder not below divisor");

	a_speed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.spd_load |=> $stable(speed_q))
		else $error("speed changed without a speed update");
`endif

endmodule
